FILE: hw/rtl/gregorian_date_subtract_core_defines.svh
// Assertion helpers used by the checker of this block.
`ifndef GREGORIAN_DATE_SUBTRACT_CORE_DEFINES_SVH
`define GREGORIAN_DATE_SUBTRACT_CORE_DEFINES_SVH

// Same-cycle implication, disabled while reset is low.
`define GDS_ASSERT_IMP(lbl, clk_s, rst_s, ante, cons, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is low.
`define GDS_ASSERT_NXT(lbl, clk_s, rst_s, ante, cons, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hw/rtl/gds_pkg.sv
`timescale 1ns / 1ps
package gds_pkg;

  localparam int ActW   = 4;
  localparam int CountW = 10;
  localparam int DayW   = 5;
  localparam int MonthW = 4;
  localparam int YearW  = 16;
  // count after the x7 expansion of week mode
  localparam int StepW  = 13;
  localparam int UpcW   = 5;

  localparam int MaxCountDef = 1023;
  localparam int CountMax    = (1 << CountW) - 1;

  localparam logic [ActW-1:0] ACT_DAYS         = 4'd0;
  localparam logic [ActW-1:0] ACT_WEEKS        = 4'd1;
  localparam logic [ActW-1:0] ACT_MONTHS       = 4'd2;
  localparam logic [ActW-1:0] ACT_YEARS_STEP   = 4'd3;
  localparam logic [ActW-1:0] ACT_YEARS_DIR    = 4'd4;
  localparam logic [ActW-1:0] ACT_DECADES_STEP = 4'd5;
  localparam logic [ActW-1:0] ACT_DECADES_DIR  = 4'd6;
  localparam logic [ActW-1:0] ACT_CENTURY      = 4'd7;
  localparam logic [ActW-1:0] ACT_MILLENNIUM   = 4'd8;

  localparam logic [MonthW-1:0] MonthJan = 4'd1;
  localparam logic [MonthW-1:0] MonthFeb = 4'd2;
  localparam logic [MonthW-1:0] MonthDec = 4'd12;
  localparam logic [DayW-1:0]   DayFirst = 5'd1;
  localparam logic [DayW-1:0]   DayDec31 = 5'd31;

  localparam logic [YearW-1:0] YearsDecade     = 16'd10;
  localparam logic [YearW-1:0] YearsCentury    = 16'd100;
  localparam logic [YearW-1:0] YearsMillennium = 16'd1000;

  localparam logic [DayW-1:0] MONTH_LEN [12] = '{
    5'd31, 5'd28, 5'd31, 5'd30, 5'd31, 5'd30,
    5'd31, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31
  };

  typedef logic [UpcW-1:0] upc_t;

  typedef enum logic [2:0] {
    DOP_NONE,
    DOP_DAY_STEP,
    DOP_MONTH_STEP,
    DOP_YEAR_SUB,
    DOP_YEAR_DIRECT,
    DOP_CLAMP_DAY,
    DOP_CLAMP_ORIG
  } dop_t;

  typedef enum logic [1:0] {
    COP_NONE,
    COP_DEC,
    COP_X7
  } cop_t;

  // JMP_ZERO and JMP_LOOP branch on a zero count and then skip the step's ops
  typedef enum logic [2:0] {
    JMP_NEXT,
    JMP_ALWAYS,
    JMP_ZERO,
    JMP_LOOP,
    JMP_DISPATCH,
    JMP_DONE
  } jmp_t;

  typedef struct packed {
    dop_t dop;
    cop_t cop;
    jmp_t jmp;
    upc_t target;
  } uword_t;

  typedef enum logic {
    SEQ_IDLE,
    SEQ_RUN
  } seq_state_t;

  localparam upc_t UPC_START  = 5'd0;
  localparam upc_t UPC_DISP   = 5'd3;
  localparam upc_t UPC_WEEKS  = 5'd4;
  localparam upc_t UPC_DAYS   = 5'd5;
  localparam upc_t UPC_MONTHS = 5'd6;
  localparam upc_t UPC_YSTEP  = 5'd7;
  localparam upc_t UPC_YCLAMP = 5'd11;
  localparam upc_t UPC_YDIR   = 5'd12;
  localparam upc_t UPC_WAIT   = 5'd13;
  localparam upc_t UPC_CLAMPO = 5'd16;
  localparam upc_t UPC_FIN    = 5'd17;

  function automatic logic [DayW-1:0] days_in(input logic [MonthW-1:0] m, input logic leap);
    logic [DayW-1:0] len;
    begin
      if (m == MonthFeb) begin
        len = leap ? 5'd29 : 5'd28;
      end else if (m >= MonthJan && m <= MonthDec) begin
        len = MONTH_LEN[m - MonthJan];
      end else begin
        len = '0;
      end
      return len;
    end
  endfunction

  // Steps 0..2 and the three waits before each clamp cover the leap pipeline.
  function automatic uword_t ucode_rom(input upc_t a);
    uword_t w;
    begin
      w = '{dop: DOP_NONE, cop: COP_NONE, jmp: JMP_NEXT, target: UPC_FIN};
      case (a)
        5'd0, 5'd1, 5'd2: w.jmp = JMP_NEXT;
        UPC_DISP:   w.jmp = JMP_DISPATCH;
        UPC_WEEKS:  w = '{dop: DOP_NONE, cop: COP_X7, jmp: JMP_ALWAYS, target: UPC_DAYS};
        UPC_DAYS:   w = '{dop: DOP_DAY_STEP, cop: COP_DEC, jmp: JMP_LOOP, target: UPC_FIN};
        UPC_MONTHS: w = '{dop: DOP_MONTH_STEP, cop: COP_DEC, jmp: JMP_LOOP, target: UPC_WAIT};
        UPC_YSTEP:  w = '{dop: DOP_YEAR_SUB, cop: COP_DEC, jmp: JMP_ZERO, target: UPC_FIN};
        5'd8, 5'd9, 5'd10: w.jmp = JMP_NEXT;
        UPC_YCLAMP: w = '{dop: DOP_CLAMP_DAY, cop: COP_NONE, jmp: JMP_ALWAYS,
                          target: UPC_YSTEP};
        UPC_YDIR:   w = '{dop: DOP_YEAR_DIRECT, cop: COP_NONE, jmp: JMP_NEXT,
                          target: UPC_FIN};
        UPC_WAIT, 5'd14, 5'd15: w.jmp = JMP_NEXT;
        UPC_CLAMPO: w = '{dop: DOP_CLAMP_ORIG, cop: COP_NONE, jmp: JMP_ALWAYS,
                          target: UPC_FIN};
        UPC_FIN:    w.jmp = JMP_DONE;
        default:    w.jmp = JMP_ALWAYS;
      endcase
      return w;
    end
  endfunction

endpackage

FILE: hw/rtl/gds_if.sv
`timescale 1ns / 1ps
interface gds_in_if import gds_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic [ActW-1:0]          action;
  logic [CountW-1:0]        step_count;
  logic [DayW-1:0]          in_day;
  logic [MonthW-1:0]        in_month;
  logic signed [YearW-1:0]  in_year;

  modport source (output valid, action, step_count, in_day, in_month, in_year,
                  input ready);
  modport sink   (input valid, action, step_count, in_day, in_month, in_year,
                  output ready);
endinterface

interface gds_out_if import gds_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic [DayW-1:0]          out_day;
  logic [MonthW-1:0]        out_month;
  logic signed [YearW-1:0]  out_year;

  modport source (output valid, out_day, out_month, out_year, input ready);
  modport sink   (input valid, out_day, out_month, out_year, output ready);
endinterface

FILE: hw/rtl/gds_leap.sv
`timescale 1ns / 1ps
// Three-stage leap-year test on a two's complement year.
// |y| mod 100 through a reciprocal multiply, exact for |y| <= 32768.
module gds_leap import gds_pkg::*; (
  input  logic             clk,
  input  logic [YearW-1:0] year,
  output logic             leap
);

  localparam int RecipHundred = 5243;
  localparam int RecipShift   = 19;
  localparam int ProdW        = YearW + 13;
  localparam int QuoW         = 9;

  logic [YearW-1:0] abs1_r, abs2_r;
  logic             by4_1_r, by4_2_r;
  logic [ProdW-1:0] prod;
  logic [QuoW-1:0]  quo_r;
  logic [YearW-1:0] hund;
  logic             by100, by400;
  logic             leap_r;

  assign prod  = ProdW'(abs1_r) * ProdW'(RecipHundred);
  assign hund  = YearW'(quo_r) * YearW'(100);
  assign by100 = (hund == abs2_r);
  assign by400 = by100 && (quo_r[1:0] == 2'b00);

  always_ff @(posedge clk) begin
    abs1_r  <= year[YearW-1] ? (~year + 1'b1) : year;
    by4_1_r <= (year[1:0] == 2'b00);
    quo_r   <= prod[RecipShift +: QuoW];
    abs2_r  <= abs1_r;
    by4_2_r <= by4_1_r;
    leap_r  <= (by4_2_r && !by100) || by400;
  end

  assign leap = leap_r;

endmodule

FILE: hw/rtl/gregorian_date_subtract_core.sv
`timescale 1ns / 1ps
// Gregorian date decrement. One item at a time: in_ch is ready while the
// sequencer is idle, and a result sits in an output register so the next
// item can be taken while it waits. The microcode program issues one control
// word per cycle, and holds on its final word while the output register is
// still full. The day loop is the long path; the leap pipeline accounts for
// the waits before every clamp. MAX_COUNT saturates the step count.
module gregorian_date_subtract_core import gds_pkg::*; #(
  parameter int MAX_COUNT = MaxCountDef
) (
  input  logic       clk,
  input  logic       rst_n,
  gds_in_if.sink     in_ch,
  gds_out_if.source  out_ch
);

  localparam int SatCountI = (MAX_COUNT > CountMax) ? CountMax : MAX_COUNT;
  localparam logic [CountW-1:0] SatCount = SatCountI[CountW-1:0];

  seq_state_t       state_r, state_nxt;
  upc_t             pc_r, pc_nxt;
  uword_t           uw;
  logic             accept, exec, load_out, cnt_zero, leap;
  upc_t             disp_tgt;

  logic [ActW-1:0]   act_r, act_nxt;
  logic [StepW-1:0]  cnt_r, cnt_nxt;
  logic [DayW-1:0]   day_r, day_nxt, orig_r, orig_nxt;
  logic [MonthW-1:0] month_r, month_nxt;
  logic [YearW-1:0]  year_r, year_nxt;
  logic [CountW-1:0] count_sat;
  logic [DayW-1:0]   day_fix, mlen_cur, mlen_prev;
  logic [MonthW-1:0] month_fix;
  logic [YearW-1:0]  cnt_wide, back;

  logic              out_valid_r, out_valid_nxt;
  logic [DayW-1:0]   out_day_r;
  logic [MonthW-1:0] out_month_r;
  logic [YearW-1:0]  out_year_r;

  gds_leap u_leap (
    .clk  (clk),
    .year (year_r),
    .leap (leap)
  );

  assign uw       = ucode_rom(pc_r);
  assign cnt_zero = (cnt_r == '0);
  assign accept   = in_ch.valid && in_ch.ready;

  always_comb begin
    case (act_r)
      ACT_DAYS:                           disp_tgt = UPC_DAYS;
      ACT_WEEKS:                          disp_tgt = UPC_WEEKS;
      ACT_MONTHS:                         disp_tgt = UPC_MONTHS;
      ACT_YEARS_STEP, ACT_DECADES_STEP:   disp_tgt = UPC_YSTEP;
      ACT_YEARS_DIR, ACT_DECADES_DIR,
      ACT_CENTURY, ACT_MILLENNIUM:        disp_tgt = UPC_YDIR;
      default:                            disp_tgt = UPC_FIN;
    endcase
  end

  // sequencer
  always_comb begin
    state_nxt   = state_r;
    pc_nxt      = pc_r;
    exec        = 1'b0;
    load_out    = 1'b0;
    in_ch.ready = 1'b0;
    case (state_r)
      SEQ_IDLE: begin
        in_ch.ready = 1'b1;
        if (in_ch.valid) begin
          state_nxt = SEQ_RUN;
          pc_nxt    = UPC_START;
        end
      end
      SEQ_RUN: begin
        case (uw.jmp)
          JMP_NEXT: begin
            exec   = 1'b1;
            pc_nxt = pc_r + 1'b1;
          end
          JMP_ALWAYS: begin
            exec   = 1'b1;
            pc_nxt = uw.target;
          end
          JMP_ZERO: begin
            if (cnt_zero) begin
              pc_nxt = uw.target;
            end else begin
              exec   = 1'b1;
              pc_nxt = pc_r + 1'b1;
            end
          end
          JMP_LOOP: begin
            if (cnt_zero) begin
              pc_nxt = uw.target;
            end else begin
              exec = 1'b1;
            end
          end
          JMP_DISPATCH: pc_nxt = disp_tgt;
          JMP_DONE: begin
            if (!out_valid_r || out_ch.ready) begin
              load_out  = 1'b1;
              state_nxt = SEQ_IDLE;
            end
          end
          default: pc_nxt = UPC_FIN;
        endcase
      end
      default: state_nxt = SEQ_IDLE;
    endcase
  end

  // input corrections
  assign count_sat = (in_ch.step_count > SatCount) ? SatCount : in_ch.step_count;
  assign day_fix   = (in_ch.in_day == '0) ? DayFirst : in_ch.in_day;
  always_comb begin
    if (in_ch.in_month < MonthJan) begin
      month_fix = MonthJan;
    end else if (in_ch.in_month > MonthDec) begin
      month_fix = MonthDec;
    end else begin
      month_fix = in_ch.in_month;
    end
  end

  assign mlen_cur  = days_in(month_r, leap);
  assign mlen_prev = days_in(month_r - 1'b1, leap);
  assign cnt_wide  = YearW'(cnt_r);

  always_comb begin
    case (act_r)
      ACT_YEARS_DIR:   back = cnt_wide;
      ACT_DECADES_DIR: back = (cnt_wide << 3) + (cnt_wide << 1);
      ACT_CENTURY:     back = YearsCentury;
      ACT_MILLENNIUM:  back = YearsMillennium;
      default:         back = '0;
    endcase
  end

  // datapath
  always_comb begin
    act_nxt   = act_r;
    cnt_nxt   = cnt_r;
    day_nxt   = day_r;
    orig_nxt  = orig_r;
    month_nxt = month_r;
    year_nxt  = year_r;
    if (accept) begin
      act_nxt   = in_ch.action;
      cnt_nxt   = StepW'(count_sat);
      day_nxt   = day_fix;
      orig_nxt  = day_fix;
      month_nxt = month_fix;
      year_nxt  = in_ch.in_year;
    end else if (exec) begin
      case (uw.dop)
        DOP_DAY_STEP: begin
          if (day_r > DayFirst) begin
            day_nxt = day_r - 1'b1;
          end else if (month_r == MonthJan) begin
            month_nxt = MonthDec;
            day_nxt   = DayDec31;
            year_nxt  = year_r - 1'b1;
          end else begin
            month_nxt = month_r - 1'b1;
            day_nxt   = mlen_prev;
          end
        end
        DOP_MONTH_STEP: begin
          if (month_r == MonthJan) begin
            month_nxt = MonthDec;
            year_nxt  = year_r - 1'b1;
          end else begin
            month_nxt = month_r - 1'b1;
          end
        end
        DOP_YEAR_SUB: begin
          year_nxt = (act_r == ACT_DECADES_STEP) ? (year_r - YearsDecade)
                                                 : (year_r - 1'b1);
        end
        DOP_YEAR_DIRECT: year_nxt = year_r - back;
        DOP_CLAMP_DAY:   day_nxt = (day_r > mlen_cur) ? mlen_cur : day_r;
        DOP_CLAMP_ORIG:  day_nxt = (orig_r > mlen_cur) ? mlen_cur : orig_r;
        default: ;
      endcase
      case (uw.cop)
        COP_DEC: cnt_nxt = cnt_r - 1'b1;
        COP_X7:  cnt_nxt = (cnt_r << 3) - cnt_r;
        default: ;
      endcase
    end
  end

  assign out_valid_nxt = load_out ? 1'b1 : (out_ch.ready ? 1'b0 : out_valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= SEQ_IDLE;
      pc_r        <= UPC_START;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      pc_r        <= pc_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    act_r   <= act_nxt;
    cnt_r   <= cnt_nxt;
    day_r   <= day_nxt;
    orig_r  <= orig_nxt;
    month_r <= month_nxt;
    year_r  <= year_nxt;
    if (load_out) begin
      out_day_r   <= day_r;
      out_month_r <= month_r;
      out_year_r  <= year_r;
    end
  end

  assign out_ch.valid     = out_valid_r;
  assign out_ch.out_day   = out_day_r;
  assign out_ch.out_month = out_month_r;
  assign out_ch.out_year  = out_year_r;

endmodule

FILE: hw/rtl/gds_checker.sv
`timescale 1ns / 1ps
`include "gregorian_date_subtract_core_defines.svh"
module gds_checker import gds_pkg::*; (
  input logic              clk,
  input logic              rst_n,
  input logic              in_valid,
  input logic              in_ready,
  input logic              out_valid,
  input logic              out_ready,
  input logic [DayW-1:0]   out_day,
  input logic [MonthW-1:0] out_month,
  input logic [YearW-1:0]  out_year
);

  // a result beat that waits keeps its payload
  `GDS_ASSERT_NXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_day) && $stable(out_month) && $stable(out_year), "result changed while stalled")

  // the month of a result is always in range and its day is never zero
  `GDS_ASSERT_IMP(a_out_range, clk, rst_n, out_valid, out_month >= MonthJan && out_month <= MonthDec && out_day != '0, "result date out of range")

  // one item at a time: busy right after an accepted beat
  `GDS_ASSERT_NXT(a_busy_after_accept, clk, rst_n, in_valid && in_ready, !in_ready, "input taken while busy")

  // a new result only appears at the end of a run
  `GDS_ASSERT_IMP(a_result_from_run, clk, rst_n, $rose(out_valid), !$past(in_ready), "result without a run")

endmodule

bind gregorian_date_subtract_core gds_checker u_gds_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_ch.valid),
  .in_ready  (in_ch.ready),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_day   (out_ch.out_day),
  .out_month (out_ch.out_month),
  .out_year  (out_ch.out_year)
);
